@@ hw/rtl/smb_pkg.sv @@
// Shared types and constants for the segment-between-markers block.
`default_nettype none

package smb_pkg;

    // Longest marker in bytes, and the window of bytes kept for matching.
    localparam int MARKER_BYTES = 8;
    localparam int LEN_W        = 4;
    localparam int BYTE_IDX_W   = $clog2(MARKER_BYTES);

    // Depth of the queue between the matching front and the output back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Configuration register indexes.
    localparam logic [1:0] CFG_START_MARKER     = 2'd0;
    localparam logic [1:0] CFG_START_MARKER_LEN = 2'd1;
    localparam logic [1:0] CFG_END_MARKER       = 2'd2;
    localparam logic [1:0] CFG_END_MARKER_LEN   = 2'd3;

    typedef logic [MARKER_BYTES-1:0][7:0] t_window;

    // Phase of the string being scanned.
    typedef enum logic [1:0] {
        PH_SEEK,
        PH_COLLECT,
        PH_DONE
    } t_phase;

    // Marker configuration as seen by the front.
    typedef struct packed {
        t_window            start_marker;
        logic [LEN_W-1:0]   start_len;
        t_window            end_marker;
        logic [LEN_W-1:0]   end_len;
    } t_cfg;

    // One output job: nbytes bytes from data (lowest first), the last byte
    // flagged done when done_last is set, then one bare done item if tail.
    typedef struct packed {
        t_window            data;
        logic [LEN_W-1:0]   nbytes;
        logic               done_last;
        logic               tail;
    } t_job;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Marker length clipped to the window size.
    function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] v);
        logic [LEN_W-1:0] cap;
        cap = LEN_W'(MARKER_BYTES);
        return (v > cap) ? cap : v;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/segment_between_markers.sv @@
// Top level of the segment-between-markers block.
//
//  Channel   Direction  Ports                        Payload
//  s_axis    in         tvalid/tready/tdata/tlast    tdata = text_byte, tlast = string_end
//  m_axis    out        tvalid/tready/tdata/tuser/   tdata = segment_byte,
//                       tlast                        tuser = byte_present, tlast = segment_done
//  cfg       in         i_cfg_valid/o_cfg_ready      i_cfg_index, i_cfg_data
//
// One input byte is taken per cycle while the four-entry job queue has room;
// the marker compare over the eight-byte window finishes in that same cycle.
// The back emits one result item per cycle while m_axis_tready allows, so a byte that flushes
// the held window (up to eight items) occupies the output until all of them are taken.
// Synchronous active-low reset clears phase, window, queue and output valid.
// Output stalls back up into the queue and then into s_axis_tready.
`default_nettype none

module segment_between_markers (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,   // [7:0] text_byte
    input  wire logic         s_axis_tlast,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [7:0]        m_axis_tdata,   // [7:0] segment_byte
    output logic              m_axis_tuser,   // [0] byte_present
    output logic              m_axis_tlast,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [1:0]   i_cfg_index,
    input  wire logic [63:0]  i_cfg_data
);
    import smb_pkg::*;

    t_cfg       r_cfg;
    t_job       front_job;
    logic       front_job_valid;
    t_job       q_head;
    t_q_status  q_status;
    logic       back_pop;
    logic       in_accept;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !q_status.full;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_START_MARKER:     r_cfg.start_marker <= i_cfg_data;
                CFG_START_MARKER_LEN: r_cfg.start_len    <= i_cfg_data[LEN_W-1:0];
                CFG_END_MARKER:       r_cfg.end_marker   <= i_cfg_data;
                CFG_END_MARKER_LEN:   r_cfg.end_len      <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    smb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_byte      (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .i_cfg       (r_cfg),
        .o_job       (front_job),
        .o_job_valid (front_job_valid)
    );

    smb_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (in_accept && front_job_valid),
        .i_job    (front_job),
        .i_pop    (back_pop),
        .o_head   (q_head),
        .o_status (q_status)
    );

    smb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (q_head),
        .i_head_valid (!q_status.empty),
        .o_pop        (back_pop),
        .i_ready      (m_axis_tready),
        .o_valid      (m_axis_tvalid),
        .o_byte       (m_axis_tdata),
        .o_present    (m_axis_tuser),
        .o_done       (m_axis_tlast)
    );

    // A bare item always closes a segment and carries a zero byte.
    a_bare_is_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tlast && m_axis_tdata == 8'h00))
        else $error("bare result item without segment_done or with data");

    // The queue cannot be full and empty at once.
    a_queue_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_status.full && q_status.empty))
        else $error("job queue reports full and empty together");

    // The back pops only a job that is present.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_pop |-> !q_status.empty)
        else $error("job popped from an empty queue");

endmodule

`default_nettype wire

@@ hw/rtl/smb_front.sv @@
// Front part: tracks the marker window per byte and builds output jobs.
`default_nettype none

module smb_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_accept,
    input  wire logic [7:0]     i_byte,
    input  wire logic           i_last,
    input  wire smb_pkg::t_cfg  i_cfg,
    output smb_pkg::t_job       o_job,
    output logic                o_job_valid
);
    import smb_pkg::*;

    t_phase            r_phase, n_phase;
    t_window           r_win, n_win;
    logic [LEN_W-1:0]  r_bip, n_bip;

    logic [LEN_W-1:0]  len;
    logic [LEN_W-1:0]  bip_c;
    logic [LEN_W-1:0]  bip_p;
    logic [LEN_W-1:0]  bip_s;
    t_window           win_p;
    t_window           win_s;
    t_window           mk;
    t_window           mk_ref;
    logic              full;
    logic              hit;

    // Push the new byte into the window and compare with the active marker.
    always_comb begin
        len   = (r_phase == PH_SEEK) ? eff_len(i_cfg.start_len) : eff_len(i_cfg.end_len);
        bip_c = (r_bip > len - LEN_W'(1)) ? len - LEN_W'(1) : r_bip;
        mk    = (r_phase == PH_SEEK) ? i_cfg.start_marker : i_cfg.end_marker;
        for (int i = 0; i < MARKER_BYTES; i++) begin
            if (LEN_W'(i) < bip_c) begin
                win_p[i] = r_win[i];
            end else if (LEN_W'(i) == bip_c) begin
                win_p[i] = i_byte;
            end else begin
                win_p[i] = 8'h00;
            end
            mk_ref[i] = (LEN_W'(i) < len) ? mk[i] : 8'h00;
        end
        for (int i = 0; i < MARKER_BYTES - 1; i++) begin
            win_s[i] = win_p[i+1];
        end
        win_s[MARKER_BYTES-1] = 8'h00;
        bip_p = bip_c + LEN_W'(1);
        bip_s = bip_p - LEN_W'(1);
        full  = (bip_p == len);
        hit   = full && (win_p == mk_ref);
    end

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_SEEK: begin
                if (i_last) begin
                    n_phase = PH_SEEK;
                end else if (len != '0 && hit) begin
                    n_phase = PH_COLLECT;
                end
            end
            PH_COLLECT: begin
                if (i_last) begin
                    n_phase = PH_SEEK;
                end else if (len != '0 && hit) begin
                    n_phase = PH_DONE;
                end
            end
            PH_DONE: begin
                if (i_last) begin
                    n_phase = PH_SEEK;
                end
            end
            default: n_phase = PH_SEEK;
        endcase
    end

    // Window update and the job that this byte causes.
    always_comb begin
        n_win       = r_win;
        n_bip       = r_bip;
        o_job       = '0;
        o_job_valid = 1'b0;
        unique case (r_phase)
            PH_SEEK: begin
                if (len != '0) begin
                    if (hit) begin
                        n_win = '0;
                        n_bip = '0;
                    end else if (full) begin
                        n_win = win_s;
                        n_bip = bip_s;
                    end else begin
                        n_win = win_p;
                        n_bip = bip_p;
                    end
                end
                if (i_last) begin
                    n_win       = '0;
                    n_bip       = '0;
                    o_job.tail  = 1'b1;
                    o_job_valid = 1'b1;
                end
            end
            PH_COLLECT: begin
                if (len == '0) begin
                    // No end marker: every byte passes straight through.
                    n_win           = '0;
                    n_bip           = '0;
                    o_job.data[0]   = i_byte;
                    o_job.nbytes    = LEN_W'(1);
                    o_job.done_last = i_last;
                    o_job_valid     = 1'b1;
                end else if (hit) begin
                    // End marker complete: held bytes are dropped.
                    n_win       = '0;
                    n_bip       = '0;
                    o_job.tail  = 1'b1;
                    o_job_valid = 1'b1;
                end else begin
                    n_win      = full ? win_s : win_p;
                    n_bip      = full ? bip_s : bip_p;
                    o_job.data = win_p;
                    if (i_last) begin
                        // Oldest byte if the window is full, then the held rest.
                        n_win           = '0;
                        n_bip           = '0;
                        o_job.nbytes    = bip_p;
                        o_job.done_last = full ? (bip_s != '0) : (bip_p != '0);
                        o_job.tail      = full ? (bip_s == '0) : (bip_p == '0);
                        o_job_valid     = 1'b1;
                    end else if (full) begin
                        o_job.nbytes = LEN_W'(1);
                        o_job_valid  = 1'b1;
                    end
                end
            end
            PH_DONE: begin
                if (i_last) begin
                    n_win = '0;
                    n_bip = '0;
                end
            end
            default: begin
                n_win = '0;
                n_bip = '0;
            end
        endcase
    end

    // State registers advance on each accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SEEK;
            r_win   <= '0;
            r_bip   <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_win   <= n_win;
            r_bip   <= n_bip;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/smb_queue.sv @@
// Short job queue between the front and the back.
`default_nettype none

module smb_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire smb_pkg::t_job  i_job,
    input  wire logic           i_pop,
    output smb_pkg::t_job       o_head,
    output smb_pkg::t_q_status  o_status
);
    import smb_pkg::*;

    t_job               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wptr, r_rptr;
    logic [QPTR_W:0]    r_count;
    logic               do_push;
    logic               do_pop;

    assign o_status.full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_head         = r_mem[r_rptr];

    // Storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (QPTR_W+1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (QPTR_W+1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/smb_back.sv @@
// Back part: walks each job and emits its items through an output register.
`default_nettype none

module smb_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire smb_pkg::t_job  i_head,
    input  wire logic           i_head_valid,
    output logic                o_pop,
    input  wire logic           i_ready,
    output logic                o_valid,
    output logic [7:0]          o_byte,
    output logic                o_present,
    output logic                o_done
);
    import smb_pkg::*;

    logic [LEN_W-1:0]  r_idx;
    logic              r_valid;
    logic [7:0]        r_byte;
    logic              r_present;
    logic              r_done;

    logic              load;
    logic [LEN_W-1:0]  items;
    logic              last_item;
    logic              is_byte;

    // Item selection within the head job.
    always_comb begin
        load      = !r_valid || i_ready;
        items     = i_head.nbytes + LEN_W'(i_head.tail);
        last_item = (r_idx == items - LEN_W'(1));
        is_byte   = (r_idx < i_head.nbytes);
        o_pop     = load && i_head_valid && last_item;
    end

    // Output register and item counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            r_valid <= i_head_valid;
            if (i_head_valid) begin
                r_idx <= last_item ? '0 : r_idx + LEN_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_head_valid) begin
            r_byte    <= is_byte ? i_head.data[r_idx[BYTE_IDX_W-1:0]] : 8'h00;
            r_present <= is_byte;
            r_done    <= is_byte ? (i_head.done_last && last_item) : 1'b1;
        end
    end

    assign o_valid   = r_valid;
    assign o_byte    = r_byte;
    assign o_present = r_present;
    assign o_done    = r_done;

endmodule

`default_nettype wire

@@ tb/segment_between_markers_test.sv @@
// Self-checking testbench for segment_between_markers: marker extraction against a predictor.
`timescale 1ns / 1ps

module segment_between_markers_test;
    import smb_pkg::*;

    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 4;
    localparam int SETTLE_CYCLES = 40;
    localparam int IDLE_LIMIT    = 2000;

    // One result item: segment byte, present flag, done flag.
    typedef struct packed {
        logic [7:0] seg_byte;
        logic       present;
        logic       seg_done;
    } t_seg_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;   // [7:0] text_byte
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;        // [7:0] segment_byte
    logic        m_axis_tuser;        // [0] byte_present
    logic        m_axis_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;

    // Predictor copy of the registers and the scan state.
    logic [63:0] cfg_start_marker = '0;
    logic [3:0]  cfg_start_len = '0;
    logic [63:0] cfg_end_marker = '0;
    logic [3:0]  cfg_end_len = '0;
    t_phase      scan_phase = PH_SEEK;
    logic [63:0] held_bytes = '0;
    int          held_count = 0;

    t_seg_result pending_segment_items[$];
    logic [7:0]  text_q[$];
    int          mismatch_count = 0;
    int          burst_left = 0;
    int          idle_cycles = 0;
    int          rx_cycles = 0;
    int          rx_mode = 0;
    int          stall_run = 0;

    segment_between_markers uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #(CLK_HALF) i_clk = 1'b1;
        #(CLK_HALF) i_clk = 1'b0;
    end

    // Marker lengths above the window size act as a full window.
    function automatic int clip_len(input logic [3:0] v);
        return (v > 4'd8) ? 8 : int'(v);
    endfunction

    function automatic logic [63:0] low_bytes(input int n);
        if (n >= 8) return '1;
        return (64'd1 << (8 * n)) - 64'd1;
    endfunction

    function automatic void clear_held();
        held_bytes = '0;
        held_count = 0;
    endfunction

    function automatic void emit_item(input logic [7:0] d, input logic p, input logic dn);
        pending_segment_items.push_back('{seg_byte: d, present: p, seg_done: dn});
    endfunction

    // Shift a byte into the held window, keeping at most len-1 older bytes.
    function automatic void push_held(input logic [7:0] b, input int len);
        if (held_count > len - 1) held_count = len - 1;
        held_bytes &= low_bytes(held_count);
        held_bytes |= 64'(b) << (8 * held_count);
        held_count++;
    endfunction

    // Work out the result items caused by one accepted text byte.
    function automatic void extract_segment(input logic [7:0] b, input logic ends);
        int len;
        case (scan_phase)
            PH_SEEK: begin
                len = clip_len(cfg_start_len);
                if (len > 0) begin
                    push_held(b, len);
                    if (held_count == len) begin
                        if (held_bytes == (cfg_start_marker & low_bytes(len))) begin
                            scan_phase = PH_COLLECT;
                            clear_held();
                        end else begin
                            held_bytes >>= 8;
                            held_count--;
                        end
                    end
                end
                if (ends) begin
                    emit_item(8'h00, 1'b0, 1'b1);
                    scan_phase = PH_SEEK;
                    clear_held();
                end
            end
            PH_COLLECT: begin
                len = clip_len(cfg_end_len);
                if (len == 0) begin
                    // No end marker: every byte passes straight through.
                    clear_held();
                    emit_item(b, 1'b1, ends);
                    if (ends) scan_phase = PH_SEEK;
                end else begin
                    push_held(b, len);
                    if (held_count == len &&
                        held_bytes == (cfg_end_marker & low_bytes(len))) begin
                        emit_item(8'h00, 1'b0, 1'b1);
                        scan_phase = ends ? PH_SEEK : PH_DONE;
                        clear_held();
                    end else begin
                        if (held_count == len) begin
                            emit_item(held_bytes[7:0], 1'b1, 1'b0);
                            held_bytes >>= 8;
                            held_count--;
                        end
                        if (ends) begin
                            // Flush what is held; the last one closes the segment.
                            if (held_count == 0) begin
                                emit_item(8'h00, 1'b0, 1'b1);
                            end else begin
                                while (held_count > 0) begin
                                    emit_item(held_bytes[7:0], 1'b1, held_count == 1);
                                    held_bytes >>= 8;
                                    held_count--;
                                end
                            end
                            scan_phase = PH_SEEK;
                            clear_held();
                        end
                    end
                end
            end
            default: begin
                // Segment over: bytes are ignored until the string ends.
                if (ends) begin
                    scan_phase = PH_SEEK;
                    clear_held();
                end
            end
        endcase
    endfunction

    // Send one text byte; bursts of random length end in a random gap.
    task automatic send_byte(input logic [7:0] b, input logic ends);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= ends;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        extract_segment(b, ends);
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(12, 30)
                                                     : $urandom_range(0, 6);
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end else begin
            burst_left--;
        end
    endtask

    // Send up to eight bytes, first byte in the low bits.
    task automatic send_bytes(input logic [63:0] text, input int count, input logic ends);
        for (int k = 0; k < count; k++) send_byte(text[8*k +: 8], ends && (k == count - 1));
    endtask

    // Hold input until every expected item has come, then let the block settle.
    task automatic wait_idle();
        if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
        while (pending_segment_items.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One register write; the caller lowers the valid after the last one.
    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_START_MARKER:     cfg_start_marker = val;
            CFG_START_MARKER_LEN: cfg_start_len    = val[3:0];
            CFG_END_MARKER:       cfg_end_marker   = val;
            default:              cfg_end_len      = val[3:0];
        endcase
    endtask

    // Write all four registers back to back; length words carry random upper bits.
    task automatic set_markers(input logic [63:0] smark, input logic [3:0] slen,
                               input logic [63:0] emark, input logic [3:0] elen);
        logic [63:0] len_word;
        write_reg(CFG_START_MARKER, smark);
        len_word = {$urandom, $urandom};
        len_word[3:0] = slen;
        write_reg(CFG_START_MARKER_LEN, len_word);
        write_reg(CFG_END_MARKER, emark);
        len_word = {$urandom, $urandom};
        len_word[3:0] = elen;
        write_reg(CFG_END_MARKER_LEN, len_word);
        i_cfg_valid <= 1'b0;
    endtask

    // A narrow alphabet makes partial and overlapping marker matches common.
    function automatic logic [7:0] pick_byte(input logic narrow);
        if (narrow && $urandom_range(0, 3) != 0) return $urandom_range(0, 1) ? 8'h61 : 8'h62;
        return 8'($urandom);
    endfunction

    // With the reset configuration the start marker is never found.
    task automatic test_reset_defaults();
        send_bytes(64'h00, 1, 1'b1);
    endtask

    // Start and end marker both found; bytes after the end are ignored.
    task automatic test_marker_pair();
        wait_idle();
        set_markers(64'h00FF, 4'd2, 64'h3E3E, 4'd2);
        send_bytes(64'h7A3E3E6100FF, 6, 1'b1);
    endtask

    // End marker never completes: held bytes are flushed at string end.
    task automatic test_end_missing();
        send_bytes(64'h3E6300FF, 4, 1'b1);
    endtask

    // Start marker completes on the final byte.
    task automatic test_start_on_last();
        send_bytes(64'h00FF, 2, 1'b1);
    endtask

    // Over-long length counts as eight; a short string cannot match it.
    task automatic test_long_marker();
        logic [63:0] smark;
        smark = 64'hA500FF5AC33C817E;
        wait_idle();
        set_markers(smark, 4'd12, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0);
        send_bytes(smark, 2, 1'b1);
        send_bytes(smark, 8, 1'b0);
        send_bytes(64'h00, 1, 1'b1);
    endtask

    // End marker length shrinks while bytes are held in the middle of a string.
    task automatic test_len_change();
        wait_idle();
        set_markers(64'h53, 4'd1, 64'h3E3E3E3E, 4'd4);
        send_bytes(64'h7A79787753, 5, 1'b0);
        wait_idle();
        set_markers(64'h53, 4'd1, 64'h3E3E3E3E, 4'd2);
        send_bytes(64'h3231, 2, 1'b1);
    endtask

    // Several marker settings, mostly well-formed strings with random content.
    task automatic test_random_strings();
        logic [3:0]  start_lens[6];
        logic [3:0]  end_lens[6];
        logic [63:0] smark;
        logic [63:0] emark;
        logic        narrow;
        int          sent;
        int          quota;
        int          ns;
        int          ne;
        start_lens = '{4'd1, 4'd8, 4'd15, 4'd3, 4'd0, 4'd2};
        end_lens   = '{4'd0, 4'd8, 4'd2, 4'd12, 4'd3, 4'd1};
        for (int p = 0; p < 6; p++) begin
            narrow = (p % 2 == 1);
            smark = {$urandom, $urandom};
            emark = {$urandom, $urandom};
            for (int k = 0; k < 8; k++) begin
                smark[8*k +: 8] = pick_byte(narrow);
                emark[8*k +: 8] = pick_byte(narrow);
            end
            wait_idle();
            set_markers(smark, start_lens[p], emark, end_lens[p]);
            ns = clip_len(start_lens[p]);
            ne = clip_len(end_lens[p]);
            quota = (start_lens[p] == 4'd0) ? 3 : 8;
            sent = 0;
            while (sent < quota) begin
                text_q.delete();
                if ($urandom_range(0, 9) < 8) begin
                    repeat ($urandom_range(0, 3)) text_q.push_back(pick_byte(narrow));
                    for (int k = 0; k < ns; k++) text_q.push_back(smark[8*k +: 8]);
                    repeat ($urandom_range(0, 6)) text_q.push_back(pick_byte(narrow));
                    if ($urandom_range(0, 3) != 0)
                        for (int k = 0; k < ne; k++) text_q.push_back(emark[8*k +: 8]);
                    repeat ($urandom_range(0, 2)) text_q.push_back(pick_byte(narrow));
                end else begin
                    repeat ($urandom_range(1, 6)) text_q.push_back(pick_byte(1'b0));
                end
                if (text_q.size() == 0) text_q.push_back(pick_byte(narrow));
                for (int k = 0; k < text_q.size(); k++)
                    send_byte(text_q[k], k == text_q.size() - 1);
                sent += text_q.size();
                if ($urandom_range(0, 7) == 0) wait_idle();
            end
        end
    endtask

    // Compare each accepted result item with the oldest expectation, then pick
    // the next ready value: always ready, random, or mostly stalled.
    always @(posedge i_clk) begin : result_side
        t_seg_result want;
        logic        ready_next;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_segment_items.size() == 0) begin
                $display("%0t unexpected item: expected none, got byte %h present %b done %b",
                         $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                mismatch_count++;
            end else begin
                want = pending_segment_items.pop_front();
                if (m_axis_tdata !== want.seg_byte) begin
                    $display("%0t segment_byte: expected %h, got %h",
                             $time, want.seg_byte, m_axis_tdata);
                    mismatch_count++;
                end
                if (m_axis_tuser !== want.present) begin
                    $display("%0t byte_present: expected %b, got %b",
                             $time, want.present, m_axis_tuser);
                    mismatch_count++;
                end
                if (m_axis_tlast !== want.seg_done) begin
                    $display("%0t segment_done: expected %b, got %b",
                             $time, want.seg_done, m_axis_tlast);
                    mismatch_count++;
                end
            end
        end
        rx_cycles++;
        if (rx_cycles % 32 == 0) rx_mode = $urandom_range(0, 2);
        case (rx_mode)
            0:       ready_next = 1'b1;
            1:       ready_next = $urandom_range(0, 1);
            default: ready_next = ($urandom_range(0, 3) == 0);
        endcase
        if (stall_run >= 6) ready_next = 1'b1;
        stall_run = ready_next ? 0 : stall_run + 1;
        m_axis_tready <= ready_next;
    end

    // End the run when nothing has been accepted for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t timeout: %0d items still expected",
                     $time, pending_segment_items.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Reset once, run the tests in turn, then drain and report.
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_marker_pair();
        test_end_missing();
        test_start_on_last();
        test_long_marker();
        test_len_change();
        test_random_strings();
        wait_idle();
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ segment_between_markers.f @@
hw/rtl/smb_pkg.sv
hw/rtl/smb_front.sv
hw/rtl/smb_queue.sv
hw/rtl/smb_back.sv
hw/rtl/segment_between_markers.sv
tb/segment_between_markers_test.sv
